>>> hdl/cache_slot_allocator_oldest_clean_defines.svh
// Assertion macros for the cache slot allocator.
// Used by the top level only; depends on nothing else.
`ifndef CACHE_SLOT_ALLOCATOR_OLDEST_CLEAN_DEFINES_SVH
`define CACHE_SLOT_ALLOCATOR_OLDEST_CLEAN_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define CSA_ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("cache slot allocator check failed");

// The condition must hold in the cycle after the trigger.
`define CSA_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("cache slot allocator check failed");

`endif

>>> hdl/csa_pkg.sv
// Shared types and constants of the cache slot allocator.
// Used by csa_scan and the top level; depends on nothing.
package csa_pkg;

    localparam int SLOTS_DEF      = 128;
    localparam int OWNER_BITS_DEF = 16;
    localparam int STAMP_BITS_DEF = 32;

    localparam int CMD_W      = 3;
    localparam int OWNER_ID_W = 16;
    localparam int SLOT_IDX_W = 7;
    localparam int STATUS_W   = 2;

    localparam logic [CMD_W-1:0] CMD_GET   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DIRTY = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAN = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_SLOT = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_ABSENT  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_UPDATE
    } t_state;

    // Control of the scan unit: clear starts a new pass, take presents one slot.
    typedef struct packed {
        logic clear;
        logic take;
    } t_scan_ctl;

endpackage

>>> hdl/csa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; depends on nothing.
module csa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/csa_scan.sv
// Scan unit: one owner compare and one stamp compare, applied to one slot per cycle.
// Depends on csa_pkg for the control struct.
module csa_scan #(
    parameter int SLOTS      = csa_pkg::SLOTS_DEF,
    parameter int OWNER_BITS = csa_pkg::OWNER_BITS_DEF,
    parameter int STAMP_BITS = csa_pkg::STAMP_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  csa_pkg::t_scan_ctl       i_ctl,
    input  logic [$clog2(SLOTS)-1:0] i_idx,
    input  logic                     i_valid,
    input  logic                     i_dirty,
    input  logic [OWNER_BITS-1:0]    i_owner,
    input  logic [STAMP_BITS-1:0]    i_stamp,
    input  logic [OWNER_BITS-1:0]    i_key,
    output logic                     o_hit_found,
    output logic [$clog2(SLOTS)-1:0] o_hit_idx,
    output logic                     o_free_found,
    output logic [$clog2(SLOTS)-1:0] o_free_idx,
    output logic                     o_cln_found,
    output logic [$clog2(SLOTS)-1:0] o_cln_idx,
    output logic [OWNER_BITS-1:0]    o_cln_owner
);

    localparam int IW = $clog2(SLOTS);

    logic                  r_hit_found;
    logic [IW-1:0]         r_hit_idx;
    logic                  r_free_found;
    logic [IW-1:0]         r_free_idx;
    logic                  r_cln_found;
    logic [IW-1:0]         r_cln_idx;
    logic [OWNER_BITS-1:0] r_cln_owner;
    logic [STAMP_BITS-1:0] r_cln_stamp;

    logic owner_eq;
    logic stamp_lt;

    assign owner_eq = (i_owner == i_key);
    assign stamp_lt = (i_stamp < r_cln_stamp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_cln_found  <= 1'b0;
        end else if (i_ctl.take) begin
            if (!r_hit_found && i_valid && owner_eq) begin
                r_hit_found <= 1'b1;
                r_hit_idx   <= i_idx;
            end
            if (!r_free_found && !i_valid) begin
                r_free_found <= 1'b1;
                r_free_idx   <= i_idx;
            end
            // Strict compare keeps the lowest index among equal stamps.
            if (i_valid && !i_dirty && (!r_cln_found || stamp_lt)) begin
                r_cln_found <= 1'b1;
                r_cln_idx   <= i_idx;
                r_cln_owner <= i_owner;
                r_cln_stamp <= i_stamp;
            end
        end
    end

    assign o_hit_found  = r_hit_found;
    assign o_hit_idx    = r_hit_idx;
    assign o_free_found = r_free_found;
    assign o_free_idx   = r_free_idx;
    assign o_cln_found  = r_cln_found;
    assign o_cln_idx    = r_cln_idx;
    assign o_cln_owner  = r_cln_owner;

endmodule

>>> hdl/cache_slot_allocator_oldest_clean.sv
// Cache slot allocator, oldest clean slot replacement. Every command walks all SLOTS slots
// through the owner and stamp RAMs, one slot per cycle; the drain and update states follow, and
// its result strobes on o_done from a register loaded in the update state; busy is low again in the
// strobe cycle, so a new item may start there. The result is shown for that one cycle only and
// cannot be held off. Valid and dirty bits reset to zero; no clearing pass is needed.
// Depends on csa_pkg, csa_ram, csa_scan and the assertion macro header.
`include "cache_slot_allocator_oldest_clean_defines.svh"

module cache_slot_allocator_oldest_clean #(
    parameter int SLOTS      = csa_pkg::SLOTS_DEF,
    parameter int OWNER_BITS = csa_pkg::OWNER_BITS_DEF,
    parameter int STAMP_BITS = csa_pkg::STAMP_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [csa_pkg::CMD_W-1:0]        i_cmd,
    input  logic [csa_pkg::OWNER_ID_W-1:0]   i_owner_id,
    output logic                             o_done,
    output logic [csa_pkg::SLOT_IDX_W-1:0]   o_slot_index,
    output logic                             o_hit,
    output logic                             o_evicted,
    output logic [csa_pkg::OWNER_ID_W-1:0]   o_evicted_owner,
    output logic                             o_dirty_flag,
    output logic [csa_pkg::STATUS_W-1:0]     o_status
);

    localparam int IW = $clog2(SLOTS);

    csa_pkg::t_state    r_state;
    csa_pkg::t_state    n_state;
    csa_pkg::t_scan_ctl scan_ctl;

    logic [IW-1:0]               r_cnt;
    logic                        r_take;
    logic [IW-1:0]               r_take_idx;
    logic [csa_pkg::CMD_W-1:0]   r_cmd;
    logic [OWNER_BITS-1:0]       r_key;
    logic [SLOTS-1:0]            r_valid;
    logic [SLOTS-1:0]            r_dirty;
    logic [STAMP_BITS-1:0]       r_stamp_cnt;

    logic                              r_done;
    logic [csa_pkg::SLOT_IDX_W-1:0]    r_slot_index;
    logic                              r_hit;
    logic                              r_evicted;
    logic [csa_pkg::OWNER_ID_W-1:0]    r_evicted_owner;
    logic                              r_dirty_flag;
    logic [csa_pkg::STATUS_W-1:0]      r_status;

    logic accept;
    logic scan_on;
    logic upd_on;
    logic last;

    logic [OWNER_BITS-1:0] rd_owner;
    logic [STAMP_BITS-1:0] rd_stamp;

    logic                  hit_found;
    logic [IW-1:0]         hit_idx;
    logic                  free_found;
    logic [IW-1:0]         free_idx;
    logic                  cln_found;
    logic [IW-1:0]         cln_idx;
    logic [OWNER_BITS-1:0] cln_owner;

    // Decision of the update step.
    logic                           d_alloc;
    logic [IW-1:0]                  d_idx;
    logic                           d_valid_we;
    logic                           d_valid_val;
    logic                           d_dirty_we;
    logic                           d_dirty_val;
    logic                           d_hit;
    logic                           d_evicted;
    logic [OWNER_BITS-1:0]          d_ev_owner;
    logic                           d_dflag;
    logic [csa_pkg::STATUS_W-1:0]   d_status;
    logic                           d_report_idx;
    logic                           hit_dirty;

    assign accept = start && !busy;
    assign last   = (r_cnt == IW'(SLOTS - 1));

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            csa_pkg::ST_IDLE: begin
                if (start) n_state = csa_pkg::ST_SCAN;
            end
            csa_pkg::ST_SCAN: begin
                if (last) n_state = csa_pkg::ST_DRAIN;
            end
            csa_pkg::ST_DRAIN:  n_state = csa_pkg::ST_UPDATE;
            csa_pkg::ST_UPDATE: n_state = csa_pkg::ST_IDLE;
            default:            n_state = csa_pkg::ST_IDLE;
        endcase
    end

    // State decode.
    always_comb begin
        busy           = 1'b1;
        scan_on        = 1'b0;
        upd_on         = 1'b0;
        scan_ctl.clear = 1'b0;
        scan_ctl.take  = r_take;
        case (r_state)
            csa_pkg::ST_IDLE: begin
                busy           = 1'b0;
                scan_ctl.clear = start;
            end
            csa_pkg::ST_SCAN:   scan_on = 1'b1;
            csa_pkg::ST_DRAIN:  scan_on = 1'b0;
            csa_pkg::ST_UPDATE: upd_on  = 1'b1;
            default:            busy    = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csa_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_take  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_take  <= scan_on;
            r_done  <= upd_on;
            if (accept) begin
                r_cnt <= '0;
            end else if (scan_on) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_take_idx <= r_cnt;
        if (accept) begin
            r_cmd <= i_cmd;
            r_key <= OWNER_BITS'(i_owner_id);
        end
    end

    csa_ram #(
        .WIDTH (OWNER_BITS),
        .DEPTH (SLOTS)
    ) u_owner_ram (
        .i_clk   (i_clk),
        .i_we    (upd_on && d_alloc),
        .i_waddr (d_idx),
        .i_wdata (r_key),
        .i_raddr (r_cnt),
        .o_rdata (rd_owner)
    );

    csa_ram #(
        .WIDTH (STAMP_BITS),
        .DEPTH (SLOTS)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (upd_on && d_alloc),
        .i_waddr (d_idx),
        .i_wdata (r_stamp_cnt),
        .i_raddr (r_cnt),
        .o_rdata (rd_stamp)
    );

    csa_scan #(
        .SLOTS      (SLOTS),
        .OWNER_BITS (OWNER_BITS),
        .STAMP_BITS (STAMP_BITS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (scan_ctl),
        .i_idx        (r_take_idx),
        .i_valid      (r_valid[r_take_idx]),
        .i_dirty      (r_dirty[r_take_idx]),
        .i_owner      (rd_owner),
        .i_stamp      (rd_stamp),
        .i_key        (r_key),
        .o_hit_found  (hit_found),
        .o_hit_idx    (hit_idx),
        .o_free_found (free_found),
        .o_free_idx   (free_idx),
        .o_cln_found  (cln_found),
        .o_cln_idx    (cln_idx),
        .o_cln_owner  (cln_owner)
    );

    assign hit_dirty = r_dirty[hit_idx];

    always_comb begin
        d_alloc      = 1'b0;
        d_idx        = hit_idx;
        d_valid_we   = 1'b0;
        d_valid_val  = 1'b0;
        d_dirty_we   = 1'b0;
        d_dirty_val  = 1'b0;
        d_hit        = 1'b0;
        d_evicted    = 1'b0;
        d_ev_owner   = '0;
        d_dflag      = 1'b0;
        d_status     = csa_pkg::STAT_OK;
        d_report_idx = 1'b0;
        case (r_cmd)
            csa_pkg::CMD_GET, csa_pkg::CMD_DIRTY: begin
                if (hit_found) begin
                    d_hit        = 1'b1;
                    d_report_idx = 1'b1;
                    if (r_cmd == csa_pkg::CMD_DIRTY) begin
                        d_dirty_we  = 1'b1;
                        d_dirty_val = 1'b1;
                        d_dflag     = 1'b1;
                    end else begin
                        d_dflag = hit_dirty;
                    end
                end else if (free_found || cln_found) begin
                    d_alloc      = 1'b1;
                    d_report_idx = 1'b1;
                    d_idx        = free_found ? free_idx : cln_idx;
                    d_evicted    = !free_found;
                    d_ev_owner   = free_found ? '0 : cln_owner;
                    d_valid_we   = 1'b1;
                    d_valid_val  = 1'b1;
                    d_dirty_we   = 1'b1;
                    d_dirty_val  = (r_cmd == csa_pkg::CMD_DIRTY);
                    d_dflag      = (r_cmd == csa_pkg::CMD_DIRTY);
                end else begin
                    // Every slot is dirty: nothing changes.
                    d_status = csa_pkg::STAT_NO_SLOT;
                end
            end
            csa_pkg::CMD_FREE, csa_pkg::CMD_CLEAN, csa_pkg::CMD_QUERY: begin
                if (!hit_found) begin
                    d_status = csa_pkg::STAT_ABSENT;
                end else begin
                    d_hit        = 1'b1;
                    d_report_idx = 1'b1;
                    if (r_cmd == csa_pkg::CMD_FREE) begin
                        d_valid_we = 1'b1;
                        d_dirty_we = 1'b1;
                    end else if (r_cmd == csa_pkg::CMD_CLEAN) begin
                        d_dirty_we = 1'b1;
                    end else begin
                        d_dflag = hit_dirty;
                    end
                end
            end
            default: d_status = csa_pkg::STAT_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_dirty     <= '0;
            r_stamp_cnt <= '0;
        end else if (upd_on) begin
            if (d_valid_we) r_valid[d_idx] <= d_valid_val;
            if (d_dirty_we) r_dirty[d_idx] <= d_dirty_val;
            if (d_alloc)    r_stamp_cnt    <= r_stamp_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_on) begin
            r_slot_index    <= d_report_idx ? csa_pkg::SLOT_IDX_W'(d_idx) : '0;
            r_hit           <= d_hit;
            r_evicted       <= d_evicted;
            r_evicted_owner <= csa_pkg::OWNER_ID_W'(d_ev_owner);
            r_dirty_flag    <= d_dflag;
            r_status        <= d_status;
        end
    end

    assign o_done          = r_done;
    assign o_slot_index    = r_slot_index;
    assign o_hit           = r_hit;
    assign o_evicted       = r_evicted;
    assign o_evicted_owner = r_evicted_owner;
    assign o_dirty_flag    = r_dirty_flag;
    assign o_status        = r_status;

    `CSA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `CSA_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    `CSA_ASSERT_SAME(a_fail_empty, i_clk, i_rst_n, o_done && (o_status != csa_pkg::STAT_OK),
        !o_hit && !o_evicted && (o_slot_index == '0) && !o_dirty_flag)
    `CSA_ASSERT_SAME(a_evict_miss, i_clk, i_rst_n, o_done && o_evicted,
        !o_hit && (o_status == csa_pkg::STAT_OK))

endmodule

>>> tb/tb.sv
// Self-checking testbench for cache_slot_allocator_oldest_clean: drives slot commands,
// predicts every answer from its own copy of the slot table and checks it field by field.
// Depends on csa_pkg and the allocator RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOTS   = csa_pkg::SLOTS_DEF;
    localparam int POOL     = 160;
    localparam int WATCHDOG = 2000;
    localparam int SETTLE   = NSLOTS + 12;

    // Command codes the block does not decode; they must answer with all fields zero.
    localparam logic [csa_pkg::CMD_W-1:0] CMD_RSVD_LO = 3'd5;
    localparam logic [csa_pkg::CMD_W-1:0] CMD_RSVD_HI = 3'd7;

    typedef struct packed {
        logic [csa_pkg::SLOT_IDX_W-1:0] slot_index;
        logic                           hit;
        logic                           evicted;
        logic [csa_pkg::OWNER_ID_W-1:0] evicted_owner;
        logic                           dirty_flag;
        logic [csa_pkg::STATUS_W-1:0]   status;
    } t_alloc_answer;

    class alloc_scoreboard;
        bit                             valid [NSLOTS];
        bit                             dirty [NSLOTS];
        logic [31:0]                    stamp [NSLOTS];
        logic [csa_pkg::OWNER_ID_W-1:0] owner [NSLOTS];
        logic [31:0]                    stamp_ctr;
        t_alloc_answer                  answers_due [$];
        int                             errors;
        int                             n_cmds;
        int                             n_evict;
        int                             n_full;
        int                             n_hits;

        function new();
            foreach (valid[i]) begin
                valid[i] = 1'b0;
                dirty[i] = 1'b0;
                stamp[i] = '0;
                owner[i] = '0;
            end
            stamp_ctr = '0;
            errors    = 0;
            n_cmds    = 0;
            n_evict   = 0;
            n_full    = 0;
            n_hits    = 0;
        endfunction

        // Updates the slot table for one accepted command and returns its answer.
        function t_alloc_answer predict_answer(logic [csa_pkg::CMD_W-1:0] cmd,
                                               logic [csa_pkg::OWNER_ID_W-1:0] id);
            t_alloc_answer a;
            int            found;
            int            pick;
            a     = '0;
            found = -1;
            for (int i = 0; i < NSLOTS; i++) begin
                if (valid[i] && owner[i] == id) begin
                    found = i;
                    break;
                end
            end
            case (cmd)
                csa_pkg::CMD_GET, csa_pkg::CMD_DIRTY: begin
                    if (found >= 0) begin
                        a.hit = 1'b1;
                    end else begin
                        pick = -1;
                        for (int i = 0; i < NSLOTS; i++) begin
                            if (!valid[i]) begin
                                pick = i;
                                break;
                            end
                        end
                        if (pick < 0) begin
                            // Table full: the oldest clean slot goes, dirty slots are kept.
                            for (int i = 0; i < NSLOTS; i++) begin
                                if (!dirty[i] && (pick < 0 || stamp[pick] > stamp[i]))
                                    pick = i;
                            end
                            if (pick >= 0) begin
                                a.evicted       = 1'b1;
                                a.evicted_owner = owner[pick];
                            end
                        end
                        if (pick >= 0) begin
                            valid[pick] = 1'b1;
                            dirty[pick] = 1'b0;
                            owner[pick] = id;
                            stamp[pick] = stamp_ctr;
                            stamp_ctr   = stamp_ctr + 1;
                            found       = pick;
                        end
                    end
                    if (found < 0) begin
                        a.status = csa_pkg::STAT_NO_SLOT;
                    end else begin
                        if (cmd == csa_pkg::CMD_DIRTY)
                            dirty[found] = 1'b1;
                        a.slot_index = csa_pkg::SLOT_IDX_W'(found);
                        a.dirty_flag = dirty[found];
                    end
                end
                csa_pkg::CMD_FREE, csa_pkg::CMD_CLEAN, csa_pkg::CMD_QUERY: begin
                    if (found < 0) begin
                        a.status = csa_pkg::STAT_ABSENT;
                    end else begin
                        a.slot_index = csa_pkg::SLOT_IDX_W'(found);
                        a.hit        = 1'b1;
                        if (cmd == csa_pkg::CMD_FREE) begin
                            valid[found] = 1'b0;
                            dirty[found] = 1'b0;
                        end else if (cmd == csa_pkg::CMD_CLEAN) begin
                            dirty[found] = 1'b0;
                        end
                        a.dirty_flag = (cmd == csa_pkg::CMD_FREE) ? 1'b0 : dirty[found];
                    end
                end
                default: ;
            endcase
            return a;
        endfunction

        function void note_command(logic [csa_pkg::CMD_W-1:0] cmd,
                                   logic [csa_pkg::OWNER_ID_W-1:0] id);
            t_alloc_answer a;
            a = predict_answer(cmd, id);
            n_cmds++;
            if (a.evicted)
                n_evict++;
            if (a.status == csa_pkg::STAT_NO_SLOT)
                n_full++;
            if (a.hit)
                n_hits++;
            answers_due.push_back(a);
        endfunction

        function void check_field(string name, longint exp, longint act);
            if (exp != act) begin
                $error("%s: expected %0d, got %0d", name, exp, act);
                errors++;
            end
        endfunction

        function void check_answer(t_alloc_answer got);
            t_alloc_answer exp;
            if (answers_due.size() == 0) begin
                $error("answer strobed with no command outstanding");
                errors++;
                return;
            end
            exp = answers_due.pop_front();
            check_field("slot_index", exp.slot_index, got.slot_index);
            check_field("hit", exp.hit, got.hit);
            check_field("evicted", exp.evicted, got.evicted);
            check_field("evicted_owner", exp.evicted_owner, got.evicted_owner);
            check_field("dirty_flag", exp.dirty_flag, got.dirty_flag);
            check_field("status", exp.status, got.status);
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic [csa_pkg::CMD_W-1:0]      i_cmd;
    logic [csa_pkg::OWNER_ID_W-1:0] i_owner_id;
    logic                           o_done;
    logic [csa_pkg::SLOT_IDX_W-1:0] o_slot_index;
    logic                           o_hit;
    logic                           o_evicted;
    logic [csa_pkg::OWNER_ID_W-1:0] o_evicted_owner;
    logic                           o_dirty_flag;
    logic [csa_pkg::STATUS_W-1:0]   o_status;

    alloc_scoreboard                sb = new();
    int                             idle_pct;
    int                             quiet_cycles;
    logic [csa_pkg::OWNER_ID_W-1:0] owner_pool [POOL];

    cache_slot_allocator_oldest_clean dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_owner_id     (i_owner_id),
        .o_done         (o_done),
        .o_slot_index   (o_slot_index),
        .o_hit          (o_hit),
        .o_evicted      (o_evicted),
        .o_evicted_owner(o_evicted_owner),
        .o_dirty_flag   (o_dirty_flag),
        .o_status       (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_answer({o_slot_index, o_hit, o_evicted, o_evicted_owner,
                             o_dirty_flag, o_status});
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    // Holds start high until the block takes the item; idles first at the current rate.
    task automatic issue(input logic [csa_pkg::CMD_W-1:0] cmd,
                         input logic [csa_pkg::OWNER_ID_W-1:0] id);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_cmd      <= cmd;
        i_owner_id <= id;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        sb.note_command(cmd, id);
    endtask

    task automatic random_mix(input int count);
        int                             r;
        logic [csa_pkg::CMD_W-1:0]      cmd;
        logic [csa_pkg::OWNER_ID_W-1:0] id;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            if (r < 35)
                cmd = csa_pkg::CMD_GET;
            else if (r < 55)
                cmd = csa_pkg::CMD_DIRTY;
            else if (r < 65)
                cmd = csa_pkg::CMD_FREE;
            else if (r < 80)
                cmd = csa_pkg::CMD_CLEAN;
            else if (r < 96)
                cmd = csa_pkg::CMD_QUERY;
            else
                cmd = csa_pkg::CMD_W'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
            if ($urandom_range(99) < 95)
                id = owner_pool[$urandom_range(POOL - 1)];
            else
                id = csa_pkg::OWNER_ID_W'($urandom_range(16'hFFFF));
            issue(cmd, id);
        end
    endtask

    // Marking more distinct owners dirty than there are slots leaves every slot dirty,
    // so the misses that follow must be refused.
    task automatic dirty_fill();
        logic [csa_pkg::OWNER_ID_W-1:0] order [POOL];
        logic [csa_pkg::OWNER_ID_W-1:0] tmp;
        int                             j;
        order = owner_pool;
        for (int i = 0; i < POOL; i++) begin
            j        = $urandom_range(POOL - 1, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < NSLOTS + 12; i++)
            issue(csa_pkg::CMD_DIRTY, order[i]);
        for (int i = 0; i < 10; i++)
            issue(($urandom_range(1) != 0) ? csa_pkg::CMD_GET : csa_pkg::CMD_DIRTY,
                  csa_pkg::OWNER_ID_W'($urandom_range(16'hFFFF)));
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_cmd      <= csa_pkg::CMD_GET;
        i_owner_id <= '0;
        idle_pct   = 0;
        foreach (owner_pool[i])
            owner_pool[i] = csa_pkg::OWNER_ID_W'($urandom_range(16'hFFFF));
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: absent owners, allocation, hits, dirty handling, reuse of a freed slot.
        issue(csa_pkg::CMD_QUERY, 16'hFFFF);
        issue(csa_pkg::CMD_FREE, 16'hFFFF);
        issue(csa_pkg::CMD_CLEAN, 16'h0000);
        issue(csa_pkg::CMD_GET, 16'h0000);
        issue(csa_pkg::CMD_GET, 16'h0000);
        issue(csa_pkg::CMD_DIRTY, 16'hFFFF);
        issue(csa_pkg::CMD_QUERY, 16'hFFFF);
        issue(csa_pkg::CMD_DIRTY, 16'h0000);
        issue(csa_pkg::CMD_CLEAN, 16'hFFFF);
        issue(csa_pkg::CMD_QUERY, 16'hFFFF);
        issue(csa_pkg::CMD_FREE, 16'h0000);
        issue(csa_pkg::CMD_QUERY, 16'h0000);
        issue(csa_pkg::CMD_GET, 16'h8000);
        issue(csa_pkg::CMD_DIRTY, 16'h5555);
        issue(csa_pkg::CMD_GET, 16'hAAAA);
        issue(CMD_RSVD_LO, 16'hFFFF);
        issue(CMD_RSVD_LO + 3'd1, 16'h0000);
        issue(CMD_RSVD_HI, 16'hAAAA);
        issue(csa_pkg::CMD_FREE, 16'hFFFF);
        issue(csa_pkg::CMD_DIRTY, 16'hFFFF);

        // Random phases: no idling, sender idle 65%, receiver stall (not possible here),
        // and both at 38%.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                1:       idle_pct = 65;
                3:       idle_pct = 38;
                default: idle_pct = 0;
            endcase
            random_mix(125);
            dirty_fill();
            random_mix(125);
        end
        start <= 1'b0;

        while (sb.answers_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("tb: %0d commands checked: %0d hits, %0d evictions,",
                 sb.n_cmds, sb.n_hits, sb.n_evict);
        $display("tb: %0d misses refused on a table of dirty slots", sb.n_full);
        if (sb.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule
